// ----- design/b64d_pkg.sv -----
// Package for the base64 stream decoder: shared types, codes and the
// character map. Every other design file but the two channel interfaces depends on this package.
package b64d_pkg;

  // Width of the per-string byte counter.
  localparam int LenBits = 16;
  // Largest byte count that the counter can hold, as a 33-bit value.
  localparam logic [32:0] LenMax = 33'((34'd1 << LenBits) - 34'd1);
  // A single input byte causes at most three data bytes and one status report.
  localparam int MaxResults = 4;
  localparam int CountW = $clog2(MaxResults + 1);
  localparam int IdxW = $clog2(MaxResults);

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatInvalid  = 2'd1;
  localparam logic [1:0] StatOverflow = 2'd2;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [1:0] {
    ClsValue,
    ClsSkip,
    ClsPad,
    ClsBad
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic [5:0]  val;
  } char_map_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [15:0] total_length;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0]          count;
    result_t [MaxResults-1:0]   slot;
  } bundle_t;

  function automatic char_map_t map_char(input logic [7:0] c);
    char_map_t m;
    m.cls = ClsValue;
    m.val = 6'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      m.val = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      m.val = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      m.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      m.val = 6'd62;
    end else if (c == 8'h2F) begin
      m.val = 6'd63;
    end else if (c == 8'h0A) begin
      m.cls = ClsSkip;
    end else if (c == 8'h3D) begin
      m.cls = ClsPad;
    end else begin
      m.cls = ClsBad;
    end
    return m;
  endfunction

endpackage

// ----- design/b64d_in_if.sv -----
// Input channel interface of the base64 stream decoder: one text byte per
// transaction. Depends on nothing.
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ----- design/b64d_out_if.sv -----
// Result channel interface of the base64 stream decoder: one decoded byte or
// one status report per transaction. Depends on nothing.
interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [1:0]  status;
  logic [15:0] total_length;
  logic        last_result;

  modport source (output valid, output kind, output data_byte, output status,
                  output total_length, output last_result, input ready);
  modport sink   (input valid, input kind, input data_byte, input status,
                  input total_length, input last_result, output ready);
endinterface

// ----- design/b64d_decode.sv -----
// Decode stage: string state registers and the logic that turns one text
// byte into a bundle of results. Depends on b64d_pkg.
module b64d_decode
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  input  logic [15:0] max_out_len_i,
  output bundle_t     bundle_o
);

  logic [23:0]        acc_q, acc_d;
  logic [1:0]         vc_q, vc_d;
  logic               pad_q, pad_d;
  logic [1:0]         err_q, err_d;
  logic [LenBits-1:0] bc_q, bc_d;

  always_comb begin
    char_map_t          m;
    logic [32:0]        cap;
    logic [23:0]        acc_shift;
    logic [1:0]         nd;
    logic [7:0]         dbyte [3];
    logic [LenBits-1:0] fin_len;
    logic [1:0]         fin_err;

    m         = map_char(text_byte_i);
    cap       = (33'(max_out_len_i) > LenMax) ? LenMax : 33'(max_out_len_i);
    acc_shift = {acc_q[17:0], m.val};
    nd        = 2'd0;
    dbyte[0]  = 8'd0;
    dbyte[1]  = 8'd0;
    dbyte[2]  = 8'd0;
    acc_d     = acc_q;
    vc_d      = vc_q;
    pad_d     = pad_q;
    err_d     = err_q;
    bc_d      = bc_q;

    if (err_q == StatOk && !pad_q) begin
      case (m.cls)
        ClsSkip: begin
        end
        ClsPad: begin
          pad_d = 1'b1;
        end
        ClsBad: begin
          err_d = StatInvalid;
        end
        default: begin
          if (vc_q == 2'd3) begin
            if (33'(bc_q) + 33'd3 > cap) begin
              err_d = StatOverflow;
            end else begin
              dbyte[0] = acc_shift[23:16];
              dbyte[1] = acc_shift[15:8];
              dbyte[2] = acc_shift[7:0];
              nd       = 2'd3;
              bc_d     = LenBits'(bc_q + LenBits'(3));
            end
            acc_d = 24'd0;
            vc_d  = 2'd0;
          end else begin
            acc_d = acc_shift;
            vc_d  = vc_q + 2'd1;
          end
        end
      endcase
    end

    // End of string: flush the partial group, then report and clear.
    if (end_of_text_i && err_d == StatOk) begin
      if (vc_d == 2'd3) begin
        if (33'(bc_d) + 33'd2 > cap) begin
          err_d = StatOverflow;
        end else begin
          dbyte[0] = acc_d[17:10];
          dbyte[1] = acc_d[9:2];
          nd       = 2'd2;
          bc_d     = LenBits'(bc_d + LenBits'(2));
        end
      end else if (vc_d == 2'd2) begin
        if (33'(bc_d) + 33'd1 > cap) begin
          err_d = StatOverflow;
        end else begin
          dbyte[0] = acc_d[11:4];
          nd       = 2'd1;
          bc_d     = LenBits'(bc_d + LenBits'(1));
        end
      end
    end
    fin_len = bc_d;
    fin_err = err_d;
    if (end_of_text_i) begin
      acc_d = 24'd0;
      vc_d  = 2'd0;
      pad_d = 1'b0;
      err_d = StatOk;
      bc_d  = '0;
    end

    bundle_o.count = CountW'(nd) + CountW'(end_of_text_i);
    for (int i = 0; i < MaxResults; i++) begin
      if (i < 3 && 2'(i) < nd) begin
        bundle_o.slot[i].kind         = KindData;
        bundle_o.slot[i].data_byte    = dbyte[i % 3];
        bundle_o.slot[i].status       = StatOk;
        bundle_o.slot[i].total_length = 16'(bc_q + LenBits'(i + 1));
      end else begin
        bundle_o.slot[i].kind         = KindStatus;
        bundle_o.slot[i].data_byte    = 8'd0;
        bundle_o.slot[i].status       = fin_err;
        bundle_o.slot[i].total_length = 16'(fin_len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 24'd0;
      vc_q  <= 2'd0;
      pad_q <= 1'b0;
      err_q <= StatOk;
      bc_q  <= '0;
    end else if (fire_i) begin
      acc_q <= acc_d;
      vc_q  <= vc_d;
      pad_q <= pad_d;
      err_q <= err_d;
      bc_q  <= bc_d;
    end
  end

endmodule

// ----- design/b64d_out_buf.sv -----
// Result register: holds the bundle of one text byte and hands its
// results to the output channel one per transaction. Depends on b64d_pkg.
module b64d_out_buf
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  bundle_t     bundle_i,
  output logic        can_load_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     result_o,
  output logic        last_o
);

  bundle_t         bundle_q;
  logic            valid_q;
  logic [IdxW-1:0] idx_q;
  logic            take;
  logic            load;

  assign last_o      = (CountW'(idx_q) + CountW'(1)) == bundle_q.count;
  assign take        = valid_q && out_ready_i;
  assign can_load_o  = !valid_q || (take && last_o);
  assign load        = fire_i && (bundle_i.count != '0);
  assign out_valid_o = valid_q;
  assign result_o    = bundle_q.slot[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take) begin
      if (last_o) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bundle_q <= bundle_i;
    end
  end

endmodule

// ----- design/base64_stream_decoder_core.sv -----
// Top level of the base64 stream decoder: capacity register, decode stage
// and result register. Depends on b64d_pkg, the two channel interfaces,
// b64d_decode and b64d_out_buf.
//
// Usage: text bytes arrive on in_i, one per transaction, with end_of_text
// marking the last byte of a string. Decoded bytes and one final status
// report per string leave on out_o, one per transaction; last_result marks
// the last result of an input byte. The user writes the capacity register
// through cfg_we_i/cfg_wdata_i only while the block is idle (not enforced).
//
// The results of a byte are on out_o from the cycle after it is accepted.
// A byte is decoded in a single pass of logic between the string state
// registers and the result register, so a byte can be taken every cycle
// while the result register is free or frees up. A byte with results holds
// the result register until its last result is taken, and the next byte is
// accepted in the cycle its last result is taken; a byte with no result
// leaves the register free. The result register bounds the rate.
//
// When the receiver stalls, the result register holds and in_i.ready drops
// once it is full. Reset empties the result register, clears the string
// state and sets the capacity to 65535.
module base64_stream_decoder_core
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  b64d_in_if.sink     in_i,
  b64d_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] max_out_len_q;
  logic        can_load;
  logic        in_fire;
  bundle_t     bundle;
  result_t     result;
  logic        last;

  // The capacity register survives the end of a string.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_out_len_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      max_out_len_q <= cfg_wdata_i;
    end
  end

  // A byte is taken whenever the result register is free or frees up now.
  assign in_i.ready = can_load;
  assign in_fire    = in_i.valid && can_load;

  b64d_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .text_byte_i   (in_i.text_byte),
    .end_of_text_i (in_i.end_of_text),
    .max_out_len_i (max_out_len_q),
    .bundle_o      (bundle)
  );

  b64d_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .bundle_i    (bundle),
    .can_load_o  (can_load),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (result),
    .last_o      (last)
  );

  assign out_o.kind         = result.kind;
  assign out_o.data_byte    = result.data_byte;
  assign out_o.status       = result.status;
  assign out_o.total_length = result.total_length;
  assign out_o.last_result  = last;

endmodule

// ----- design/b64d_checker.sv -----
// Port-level checks for the base64 stream decoder, bound to the top level.
// Depends on b64d_pkg and base64_stream_decoder_core.
module b64d_checker
  import b64d_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_kind_i,
  input logic [1:0]  out_status_i,
  input logic [15:0] out_total_length_i,
  input logic        out_last_result_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // The status report always closes the results of its byte.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KindStatus |-> out_last_result_i)
    else $error("status report not marked last");

  // Data bytes carry an ok status and a count of at least one.
  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KindData |-> out_status_i == StatOk &&
    out_total_length_i != 16'd0)
    else $error("bad fields on data result");

  // Within a bundle, consecutive data bytes count up by one.
  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_kind_i == KindData && !out_last_result_i
    |=> out_valid_i && (out_kind_i == KindStatus ||
    out_total_length_i == $past(out_total_length_i) + 16'd1))
    else $error("data byte count does not advance");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_kind_i         (out_o.kind),
  .out_status_i       (out_o.status),
  .out_total_length_i (out_o.total_length),
  .out_last_result_i  (out_o.last_result)
);

// ----- verif/base64_stream_decoder_core_tb.sv -----
// Testbench for base64_stream_decoder_core: drives base64 text strings and
// checks every decoded byte and status report against an in-bench predictor.
// Depends on b64d_pkg, b64d_in_if, b64d_out_if and the decoder RTL.
`timescale 1ns / 1ps

module base64_stream_decoder_core_tb
  import b64d_pkg::*;
();

  localparam logic [7:0] LineFeed = 8'h0A;
  localparam logic [7:0] PadChar  = "=";

  // One expected transaction on the result channel.
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [15:0] total_length;
    logic        last_result;
  } decoded_result_t;

  typedef logic [7:0] text_q_t[$];

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  b64d_in_if  text_if ();
  b64d_out_if byte_if ();

  base64_stream_decoder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (text_if),
    .out_o       (byte_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 8 ns clock period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state for the string being decoded. The capacity mirrors the
  // register inside the block and follows every write to it.
  logic [23:0] sextet_acc   = '0;
  logic [1:0]  sextet_count = '0;
  logic        pad_flag     = 1'b0;
  logic [1:0]  err_status   = StatOk;
  logic [15:0] produced_len = '0;
  logic [15:0] out_capacity = 16'hFFFF;

  // Results still owed by the block, oldest first, and the scratch list
  // built for one text byte.
  decoded_result_t expected_output[$];
  decoded_result_t step_results[$];

  int  mismatch_count  = 0;
  int  text_bytes_sent = 0;
  // While set, neither side inserts idle cycles, so the block runs at full rate.
  bit  steady_flow     = 1'b0;

  // Splits a text byte into its class and, for alphabet characters, its
  // six-bit value.
  function automatic char_class_e classify_char(input logic [7:0] c,
                                                output logic [5:0] sextet);
    sextet = 6'd0;
    if (c >= "A" && c <= "Z") begin
      sextet = 6'(c - "A");
      return ClsValue;
    end
    if (c >= "a" && c <= "z") begin
      sextet = 6'(c - "a" + 8'd26);
      return ClsValue;
    end
    if (c >= "0" && c <= "9") begin
      sextet = 6'(c - "0" + 8'd52);
      return ClsValue;
    end
    if (c == "+") begin
      sextet = 6'd62;
      return ClsValue;
    end
    if (c == "/") begin
      sextet = 6'd63;
      return ClsValue;
    end
    if (c == LineFeed) return ClsSkip;
    if (c == PadChar) return ClsPad;
    return ClsBad;
  endfunction

  // Inverse mapping, used to build well-formed text with random content.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return "A" + 8'(v);
    if (v < 6'd52) return "a" + 8'(v - 6'd26);
    if (v < 6'd62) return "0" + 8'(v - 6'd52);
    if (v == 6'd62) return "+";
    return "/";
  endfunction

  function automatic logic [7:0] random_bad_char();
    logic [7:0] c;
    logic [5:0] unused_val;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (classify_char(c, unused_val) != ClsBad);
    return c;
  endfunction

  // Emits the n low bytes of bits, most significant first, unless the group
  // would take the string past the capacity, in which case the string is
  // marked as overflowed and nothing of the group is emitted.
  task automatic emit_bytes(input logic [23:0] bits, input int n);
    decoded_result_t data_item;
    if (int'(produced_len) + n > int'(out_capacity)) begin
      err_status = StatOverflow;
    end else begin
      for (int i = n - 1; i >= 0; i--) begin
        produced_len++;
        data_item = '{kind: KindData, data_byte: bits[8*i +: 8],
                      status: StatOk, total_length: produced_len,
                      last_result: 1'b0};
        step_results.insert(step_results.size(), data_item);
      end
    end
  endtask

  // Advances the decoder state by one accepted text byte and queues the
  // results that byte causes.
  task automatic predict_decode(input logic [7:0] c, input logic eot);
    char_class_e     cls;
    logic [5:0]      sextet;
    decoded_result_t status_item;
    step_results.delete();
    // After an error or a pad character the rest of the string is ignored.
    if (err_status == StatOk && !pad_flag) begin
      cls = classify_char(c, sextet);
      case (cls)
        ClsSkip: begin
        end
        ClsPad: begin
          pad_flag = 1'b1;
        end
        ClsBad: begin
          err_status = StatInvalid;
        end
        default: begin
          sextet_acc = {sextet_acc[17:0], sextet};
          if (sextet_count == 2'd3) begin
            emit_bytes(sextet_acc, 3);
            sextet_acc   = '0;
            sextet_count = '0;
          end else begin
            sextet_count++;
          end
        end
      endcase
    end
    if (eot) begin
      // Flush a partial group: three values give two bytes, two give one,
      // and a lone value carries too few bits for a byte. No flush follows
      // an error.
      if (err_status == StatOk) begin
        if (sextet_count == 2'd3) begin
          emit_bytes({8'h00, sextet_acc[17:2]}, 2);
        end else if (sextet_count == 2'd2) begin
          emit_bytes({16'h0000, sextet_acc[11:4]}, 1);
        end
      end
      status_item = '{kind: KindStatus, data_byte: 8'h00,
                      status: err_status, total_length: produced_len,
                      last_result: 1'b0};
      step_results.insert(step_results.size(), status_item);
      sextet_acc   = '0;
      sextet_count = '0;
      pad_flag     = 1'b0;
      err_status   = StatOk;
      produced_len = '0;
    end
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].last_result = 1'b1;
    end
    expected_output = {expected_output, step_results};
  endtask

  task automatic report_mismatch(input string msg);
    // Printing is capped so a badly broken block cannot flood the log.
    if (mismatch_count < 100) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Presents one text byte after a random gap and waits for the transaction.
  // The valid line is left high on return; the next call either keeps it
  // high with new data or drops it for a gap, so it changes once per step.
  task automatic send_text_byte(input logic [7:0] c, input logic eot);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= c;
    text_if.end_of_text <= eot;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    predict_decode(c, eot);
    text_bytes_sent++;
  endtask

  task automatic send_text(input text_q_t text);
    foreach (text[i]) send_text_byte(text[i], i == text.size() - 1);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_text_byte(s[i], i == s.len() - 1);
  endtask

  // Holds the sender until every expected result has been taken, and then
  // until a byte without results has settled as well.
  task automatic wait_drained();
    int guard;
    guard = 0;
    text_if.valid <= 1'b0;
    while (expected_output.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    out_capacity = cap;
    cfg_we_i    <= 1'b0;
  endtask

  // Short strings that hit each decoding rule at least once.
  task automatic test_directed_strings();
    send_string("TWFu");     // one full group: "Man"
    send_string("//8=");     // top values, three pending values flush two bytes
    send_string("A\n");      // line feed skipped, a lone value is dropped
    send_string("Aw=Z");     // two pending values flush one byte, text after pad ignored
    send_text_byte(8'h00, 1'b0);  // invalid at the first byte, rest ignored
    send_text_byte("9", 1'b0);
    send_text_byte(8'hFF, 1'b1);
    send_string("zz09*+");   // a group, then an invalid character after it
  endtask

  // Capacity at and around the size of the groups, including zero.
  task automatic test_capacity_limits();
    write_capacity(16'h0000);
    send_string("TWFu");     // first group already overflows
    write_capacity(16'd4);
    send_string("TWFuTWFu"); // second group would pass the capacity
    write_capacity(16'd2);
    send_string("TWE");      // two-byte flush lands exactly on the capacity
    write_capacity(16'd1);
    send_string("TWE");      // two-byte flush overflows
    write_capacity(16'hFFFF);
  endtask

  // Builds one random string. Most are well-formed text with random content;
  // the rest carry padding, an invalid character, line feeds or pure noise.
  task automatic send_random_string();
    text_q_t text;
    int      shape;
    int      n_vals;
    shape  = $urandom_range(0, 19);
    n_vals = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 16);
    for (int i = 0; i < n_vals; i++) begin
      if ($urandom_range(0, 11) == 0) text.insert(text.size(), LineFeed);
      text.insert(text.size(), sextet_char(6'($urandom_range(0, 63))));
    end
    if (shape < 4) begin
      repeat ($urandom_range(1, 2)) text.insert(text.size(), PadChar);
      if (shape == 0) begin
        repeat ($urandom_range(1, 3)) text.insert(text.size(), 8'($urandom_range(0, 255)));
      end
    end else if (shape < 7) begin
      text.insert($urandom_range(0, text.size()), random_bad_char());
    end else if (shape == 7) begin
      text.delete();
      repeat ($urandom_range(1, 6)) text.insert(text.size(), 8'($urandom_range(0, 255)));
    end else if (shape == 8) begin
      text.insert(text.size(), LineFeed);
    end
    send_text(text);
  endtask

  // Random strings in phases, each under its own capacity setting.
  task automatic test_random_streams();
    int stop_at;
    int next_phase;
    int phase;
    stop_at    = text_bytes_sent + 310;
    next_phase = text_bytes_sent;
    phase      = 0;
    while (text_bytes_sent < stop_at) begin
      if (text_bytes_sent >= next_phase) begin
        case (phase % 6)
          0: write_capacity(16'($urandom_range(1, 12)));
          1: write_capacity(16'hFFFF);
          2: write_capacity(16'($urandom_range(13, 30)));
          3: write_capacity(16'h0000);
          4: write_capacity(16'($urandom_range(0, 65535)));
          default: write_capacity(16'($urandom_range(3, 9)));
        endcase
        phase++;
        next_phase = text_bytes_sent + 50;
      end
      if ($urandom_range(0, 4) == 0) steady_flow = ~steady_flow;
      // Now and then the sender holds off until the block has emptied.
      if ($urandom_range(0, 14) == 0) wait_drained();
      send_random_string();
    end
    steady_flow = 1'b0;
  endtask

  // Result side: random stalls before each transaction.
  initial begin : result_sink
    int stall;
    byte_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        byte_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      byte_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!byte_if.valid) @(posedge clk_i);
    end
  end

  // Every result transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin
    decoded_result_t want;
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      if (expected_output.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d data=%02h status=%0d len=%0d",
                                  byte_if.kind, byte_if.data_byte, byte_if.status,
                                  byte_if.total_length));
      end else begin
        want = expected_output.pop_front();
        if (byte_if.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", byte_if.kind, want.kind));
        if (byte_if.data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte %02h, expected %02h",
                                    byte_if.data_byte, want.data_byte));
        if (byte_if.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", byte_if.status, want.status));
        if (byte_if.total_length !== want.total_length)
          report_mismatch($sformatf("total_length %0d, expected %0d",
                                    byte_if.total_length, want.total_length));
        if (byte_if.last_result !== want.last_result)
          report_mismatch($sformatf("last_result %0d, expected %0d",
                                    byte_if.last_result, want.last_result));
      end
    end
  end

  initial begin
    rst_ni              <= 1'b0;
    text_if.valid       <= 1'b0;
    text_if.text_byte   <= 8'h00;
    text_if.end_of_text <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= 16'h0000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_strings();
    test_capacity_limits();
    test_random_streams();

    wait_drained();
    if (expected_output.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_output.size()));
    end
    if (mismatch_count == 0) begin
      $display("base64_stream_decoder_core_tb: PASS");
    end else begin
      $display("base64_stream_decoder_core_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: 1 ms is many times the slowest legal run of this stimulus.
  initial begin
    #1000000;
    $display("base64_stream_decoder_core_tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/b64d_pkg.sv
design/b64d_in_if.sv
design/b64d_out_if.sv
design/b64d_decode.sv
design/b64d_out_buf.sv
design/base64_stream_decoder_core.sv
design/b64d_checker.sv
verif/base64_stream_decoder_core_tb.sv
